/* rtl/fifo_queue_with_duplicate_reject_top_defines.svh */
// Assertion macros used by the checker file of the identifier queue.
// No dependencies; included by name where assertions are written.
`ifndef FIFO_QUEUE_WITH_DUPLICATE_REJECT_TOP_DEFINES_SVH
`define FIFO_QUEUE_WITH_DUPLICATE_REJECT_TOP_DEFINES_SVH

// Property checked on every rising edge outside reset.
`define FQDR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("fqdr assertion failed");

// Property checked on every rising edge, reset included.
`define FQDR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fqdr assertion failed");

`endif

/* rtl/fqdr_pkg.sv */
// Sizes, mode codes and status codes of the identifier queue.
// No dependencies; used by the interfaces, the top level and the checker.
package fqdr_pkg;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned ID_BITS  = 16;
  localparam int unsigned PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned PID_W    = 16;
  localparam int unsigned STATUS_W = 4;
  localparam int unsigned ENTRY_W  = 16;

  localparam logic [MODE_W-1:0] MODE_ENQ        = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ        = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LIST       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LIST_CLOSE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLOSE      = 3'd4;

  localparam logic [STATUS_W-1:0] ST_ACCEPTED   = 4'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE  = 4'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 4'd2;
  localparam logic [STATUS_W-1:0] ST_SERVED     = 4'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 4'd4;
  localparam logic [STATUS_W-1:0] ST_LISTED     = 4'd5;
  localparam logic [STATUS_W-1:0] ST_CL_WAITING = 4'd6;
  localparam logic [STATUS_W-1:0] ST_CL_CLEAN   = 4'd7;
  localparam logic [STATUS_W-1:0] ST_REJ_CLOSED = 4'd8;
  localparam logic [STATUS_W-1:0] ST_IGNORED    = 4'd9;

endpackage

/* rtl/fqdr_in_if.sv */
// Request channel of the identifier queue: valid/ready plus mode and id.
// Depends on fqdr_pkg for field widths.
interface fqdr_in_if;
  logic                             valid;
  logic                             ready;
  logic [fqdr_pkg::MODE_W-1:0]      mode;
  logic [fqdr_pkg::PID_W-1:0]       patient_id;

  modport source (output valid, output mode, output patient_id, input ready);
  modport sink   (input valid, input mode, input patient_id, output ready);
endinterface

/* rtl/fqdr_out_if.sv */
// Result channel of the identifier queue: valid/ready plus status, id, last.
// Depends on fqdr_pkg for field widths.
interface fqdr_out_if;
  logic                             valid;
  logic                             ready;
  logic [fqdr_pkg::STATUS_W-1:0]    status;
  logic [fqdr_pkg::ENTRY_W-1:0]     entry_id;
  logic                             last;

  modport source (output valid, output status, output entry_id, output last, input ready);
  modport sink   (input valid, input status, input entry_id, input last, output ready);
endinterface

/* rtl/fqdr_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fqdr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold the last read word while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/fifo_queue_with_duplicate_reject_top.sv */
// Identifier queue with duplicate reject: ring of entries in one RAM plus control.
// Depends on fqdr_pkg, fqdr_in_if, fqdr_out_if and fqdr_ram.
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   mode, patient_id
//   out_o    out  valid/ready   status, entry_id, last
//
// One request at a time. Enqueue first walks the queue from the head for a
// duplicate and stops at a match; list walks every entry from the head. The
// single RAM read port is walked one entry per cycle, save where a stalled output
// holds the list walk in place. The next request is taken while the last result
// still sits in the output register. Reset is asynchronous, active low, and
// empties and opens the queue at once.
module fifo_queue_with_duplicate_reject_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  fqdr_in_if.sink    in_i,
  fqdr_out_if.source out_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RESP = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_ENQ  = 3'd3;
  localparam logic [2:0] S_DEQ  = 3'd4;
  localparam logic [2:0] S_LIST = 3'd5;

  localparam int unsigned PW = fqdr_pkg::PTR_W;
  localparam int unsigned CW = fqdr_pkg::CNT_W;
  localparam int unsigned IW = fqdr_pkg::ID_BITS;
  localparam int unsigned SW = fqdr_pkg::STATUS_W;
  localparam int unsigned EW = fqdr_pkg::ENTRY_W;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    ring_next = (p == PW'(fqdr_pkg::DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [2:0]    state_q, state_d;
  logic [PW-1:0] head_q, head_d, tail_q, tail_d, ptr_q, ptr_d;
  logic [CW-1:0] count_q, count_d, rem_q, rem_d;
  logic          closed_q, closed_d;
  logic [IW-1:0] id_q, id_d;
  logic [SW-1:0] res_q, res_d;

  logic          ovalid_q, ovalid_d;
  logic [SW-1:0] ostatus_q;
  logic [EW-1:0] oentry_q;
  logic          olast_q;

  logic          emit;
  logic [SW-1:0] emit_status;
  logic [EW-1:0] emit_id;
  logic          emit_last;
  logic          slot_free;

  logic          ram_re, ram_we;
  logic [PW-1:0] ram_raddr;
  logic [IW-1:0] ram_rdata;

  fqdr_ram #(
    .WIDTH (IW),
    .DEPTH (fqdr_pkg::DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (id_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign slot_free = !ovalid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    ptr_d       = ptr_q;
    count_d     = count_q;
    rem_d       = rem_q;
    closed_d    = closed_q;
    id_d        = id_q;
    res_d       = res_q;
    ram_re      = 1'b0;
    ram_raddr   = ptr_q;
    ram_we      = 1'b0;
    emit        = 1'b0;
    emit_status = res_q;
    emit_id     = '0;
    emit_last   = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          id_d = IW'(in_i.patient_id);
          if (in_i.mode > fqdr_pkg::MODE_CLOSE) begin
            res_d   = fqdr_pkg::ST_IGNORED;
            state_d = S_RESP;
          end else if (closed_q) begin
            res_d   = fqdr_pkg::ST_REJ_CLOSED;
            state_d = S_RESP;
          end else begin
            case (in_i.mode)
              fqdr_pkg::MODE_ENQ: begin
                if (count_q == '0) begin
                  state_d = S_ENQ;
                end else begin
                  // start the duplicate walk at the head
                  ram_re    = 1'b1;
                  ram_raddr = head_q;
                  ptr_d     = ring_next(head_q);
                  rem_d     = count_q;
                  state_d   = S_SRCH;
                end
              end
              fqdr_pkg::MODE_DEQ: begin
                if (count_q == '0) begin
                  res_d   = fqdr_pkg::ST_EMPTY;
                  state_d = S_RESP;
                end else begin
                  ram_re    = 1'b1;
                  ram_raddr = head_q;
                  state_d   = S_DEQ;
                end
              end
              fqdr_pkg::MODE_LIST, fqdr_pkg::MODE_LIST_CLOSE: begin
                if (in_i.mode == fqdr_pkg::MODE_LIST_CLOSE) begin
                  closed_d = 1'b1;
                end
                if (count_q == '0) begin
                  res_d   = fqdr_pkg::ST_EMPTY;
                  state_d = S_RESP;
                end else begin
                  ram_re    = 1'b1;
                  ram_raddr = head_q;
                  ptr_d     = ring_next(head_q);
                  rem_d     = count_q;
                  state_d   = S_LIST;
                end
              end
              fqdr_pkg::MODE_CLOSE: begin
                closed_d = 1'b1;
                res_d    = (count_q != '0) ? fqdr_pkg::ST_CL_WAITING
                                           : fqdr_pkg::ST_CL_CLEAN;
                state_d  = S_RESP;
              end
              default: begin
                res_d   = fqdr_pkg::ST_IGNORED;
                state_d = S_RESP;
              end
            endcase
          end
        end
      end

      S_SRCH: begin
        if (ram_rdata == id_q) begin
          res_d   = fqdr_pkg::ST_DUPLICATE;
          state_d = S_RESP;
        end else if (rem_q == CW'(1)) begin
          state_d = S_ENQ;
        end else begin
          ram_re = 1'b1;
          ptr_d  = ring_next(ptr_q);
          rem_d  = rem_q - 1'b1;
        end
      end

      S_ENQ: begin
        if (count_q == CW'(fqdr_pkg::DEPTH)) begin
          res_d = fqdr_pkg::ST_FULL;
        end else begin
          ram_we  = 1'b1;
          tail_d  = ring_next(tail_q);
          count_d = count_q + 1'b1;
          res_d   = fqdr_pkg::ST_ACCEPTED;
        end
        state_d = S_RESP;
      end

      S_DEQ: begin
        if (slot_free) begin
          emit        = 1'b1;
          emit_status = fqdr_pkg::ST_SERVED;
          emit_id     = EW'(ram_rdata);
          head_d      = ring_next(head_q);
          count_d     = count_q - 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_LIST: begin
        if (slot_free) begin
          emit        = 1'b1;
          emit_status = fqdr_pkg::ST_LISTED;
          emit_id     = EW'(ram_rdata);
          emit_last   = (rem_q == CW'(1));
          if (rem_q == CW'(1)) begin
            state_d = S_IDLE;
          end else begin
            // fetch the next entry while this one leaves
            ram_re = 1'b1;
            ptr_d  = ring_next(ptr_q);
            rem_d  = rem_q - 1'b1;
          end
        end
      end

      S_RESP: begin
        if (slot_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      ovalid_d = 1'b1;
    end else if (out_o.ready) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      closed_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      closed_q <= closed_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    rem_q <= rem_d;
    id_q  <= id_d;
    res_q <= res_d;
    if (emit) begin
      ostatus_q <= emit_status;
      oentry_q  <= emit_id;
      olast_q   <= emit_last;
    end
  end

  assign out_o.valid    = ovalid_q;
  assign out_o.status   = ostatus_q;
  assign out_o.entry_id = oentry_q;
  assign out_o.last     = olast_q;

endmodule

/* rtl/fqdr_checker.sv */
// Port-level checks on the identifier queue, bound to the top level.
// Depends on fqdr_pkg and fifo_queue_with_duplicate_reject_top_defines.svh.
`include "fifo_queue_with_duplicate_reject_top_defines.svh"

module fqdr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [fqdr_pkg::STATUS_W-1:0] out_status_i,
  input logic [fqdr_pkg::ENTRY_W-1:0]  out_entry_id_i,
  input logic                          out_last_i
);

  // a waiting result stays until taken
  `FQDR_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)

  // only a listing transaction spreads over several results
  `FQDR_ASSERT(a_single_last, clk_i, rst_ni, out_valid_i && out_status_i != fqdr_pkg::ST_LISTED |-> out_last_i)

  // identifiers travel only with served and listed results
  `FQDR_ASSERT(a_id_zero, clk_i, rst_ni, out_valid_i && out_status_i != fqdr_pkg::ST_LISTED && out_status_i != fqdr_pkg::ST_SERVED |-> out_entry_id_i == '0)

  `FQDR_ASSERT(a_status_range, clk_i, rst_ni, out_valid_i |-> out_status_i <= fqdr_pkg::ST_IGNORED)

  // nothing leaves during reset
  `FQDR_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_i)

endmodule

bind fifo_queue_with_duplicate_reject_top fqdr_checker u_fqdr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_status_i   (out_o.status),
  .out_entry_id_i (out_o.entry_id),
  .out_last_i     (out_o.last)
);
